// ===== hw/rtl/sli_pkg.sv =====
// Shared types and constants for the sorted list insert/remove block.
// No dependencies; used by sli_ctrl and sorted_list_insert_remove.
package sli_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int COUNT_OUT_W  = 5;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_EMPTY     = 2'd3;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

endpackage

// ===== hw/rtl/sli_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register read data on enable
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/sli_ctrl.sv =====
// Sequencer for the sorted list: walks the entry memory one entry per cycle,
// shifting entries while it searches. Depends on sli_pkg.
module sli_ctrl #(
  parameter int CAPACITY = sli_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          req_type,
  input  logic signed [sli_pkg::VALUE_W-1:0] value,
  output logic                          busy,
  output logic                          done,
  output sli_pkg::status_t              status,
  output logic [sli_pkg::COUNT_OUT_W-1:0] entry_count,
  // memory port
  output logic                          mem_we,
  output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
  output logic [sli_pkg::VALUE_W-1:0]   mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
  input  logic [sli_pkg::VALUE_W-1:0]   mem_rdata
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_INS, S_INS_LAST, S_REM} state_t;

  state_t                             state, state_next;
  logic [CNT_W-1:0]                   count, count_next;
  logic [IDX_W-1:0]                   scan_idx, scan_idx_next;
  logic                               found, found_next;
  logic signed [sli_pkg::VALUE_W-1:0] val, val_next;
  logic                               done_next;
  sli_pkg::status_t                   status_q, status_next;

  logic signed [sli_pkg::VALUE_W-1:0] rd_val;
  logic                               last;
  logic                               hit;

  assign rd_val = $signed(mem_rdata);
  assign last   = (CNT_W'(scan_idx) == count - 1'b1);
  assign hit    = found || (rd_val == val);

  // Compute next state and memory accesses
  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_idx_next = scan_idx;
    found_next    = found;
    val_next      = val;
    done_next     = 1'b0;
    status_next   = status_q;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = val;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          val_next = value;
          if (req_type == sli_pkg::REQ_INSERT) begin
            if (count == CNT_W'(CAPACITY)) begin
              done_next   = 1'b1;
              status_next = sli_pkg::ST_FULL;
            end else if (count == '0) begin
              // empty list: place the value directly
              mem_we      = 1'b1;
              mem_waddr   = '0;
              mem_wdata   = value;
              count_next  = CNT_W'(1);
              done_next   = 1'b1;
              status_next = sli_pkg::ST_OK;
            end else begin
              // start at the top entry and walk down
              mem_re        = 1'b1;
              mem_raddr     = IDX_W'(count - 1'b1);
              scan_idx_next = IDX_W'(count - 1'b1);
              state_next    = S_INS;
            end
          end else begin
            if (count == '0) begin
              done_next   = 1'b1;
              status_next = sli_pkg::ST_EMPTY;
            end else begin
              // start at the bottom entry and walk up
              mem_re        = 1'b1;
              mem_raddr     = '0;
              scan_idx_next = '0;
              found_next    = 1'b0;
              state_next    = S_REM;
            end
          end
        end
      end

      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = scan_idx + 1'b1;
        if (rd_val >= val) begin
          // shift this entry up one place
          mem_wdata = mem_rdata;
          if (scan_idx == '0) begin
            state_next = S_INS_LAST;
          end else begin
            mem_re        = 1'b1;
            mem_raddr     = scan_idx - 1'b1;
            scan_idx_next = scan_idx - 1'b1;
          end
        end else begin
          // insertion point found above this entry
          mem_wdata   = val;
          count_next  = count + 1'b1;
          done_next   = 1'b1;
          status_next = sli_pkg::ST_OK;
          state_next  = S_IDLE;
        end
      end

      S_INS_LAST: begin
        mem_we      = 1'b1;
        mem_waddr   = '0;
        mem_wdata   = val;
        count_next  = count + 1'b1;
        done_next   = 1'b1;
        status_next = sli_pkg::ST_OK;
        state_next  = S_IDLE;
      end

      S_REM: begin
        // once the match is passed, move each entry down one place
        if (found) begin
          mem_we    = 1'b1;
          mem_waddr = scan_idx - 1'b1;
          mem_wdata = mem_rdata;
        end
        if (last) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (hit) begin
            count_next  = count - 1'b1;
            status_next = sli_pkg::ST_OK;
          end else begin
            status_next = sli_pkg::ST_NOT_FOUND;
          end
        end else begin
          mem_re        = 1'b1;
          mem_raddr     = scan_idx + 1'b1;
          scan_idx_next = scan_idx + 1'b1;
          found_next    = hit;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    scan_idx <= scan_idx_next;
    found    <= found_next;
    val      <= val_next;
    status_q <= status_next;
  end

  assign busy        = (state != S_IDLE);
  assign status      = status_q;
  assign entry_count = sli_pkg::COUNT_OUT_W'(count);

endmodule

// ===== hw/rtl/sorted_list_insert_remove.sv =====
// Sorted list of signed 32-bit values with insert and remove requests.
// Full, empty, and insert into an empty list raise done in the cycle after accept;
// other requests first walk the entries (at most the count), one entry per cycle.
// One transaction at a time: busy stays high while the walk over the entry RAM runs.
// Results cannot be stalled.
// Reset (rst, synchronous) empties the list; RAM contents are not cleared.
module sorted_list_insert_remove #(
  parameter int CAPACITY = sli_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic signed [sli_pkg::VALUE_W-1:0]  value,
  output logic                                done,
  output logic [1:0]                          status,
  output logic [sli_pkg::COUNT_OUT_W-1:0]     entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [sli_pkg::VALUE_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [IDX_W-1:0]            mem_raddr;
  logic [sli_pkg::VALUE_W-1:0] mem_rdata;
  sli_pkg::status_t            status_w;

  // Sequencer
  sli_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req_type    (req_type),
    .value       (value),
    .busy        (busy),
    .done        (done),
    .status      (status_w),
    .entry_count (entry_count),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // Entry storage
  sli_ram #(.WIDTH(sli_pkg::VALUE_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign status = status_w;

  // Check sequencing and status consistency
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither running nor finished");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !done)
    else $error("result without a transaction");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == sli_pkg::ST_FULL) |->
      entry_count == sli_pkg::COUNT_OUT_W'(CAPACITY))
    else $error("full status with wrong count");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == sli_pkg::ST_EMPTY) |-> entry_count == '0)
    else $error("empty status with nonzero count");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for sorted_list_insert_remove: random and directed
// insert/remove transactions checked against an in-bench sorted list model.
// Depends on sli_pkg and the sorted_list_insert_remove RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY      = sli_pkg::DEF_CAPACITY;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = CAPACITY + 4;
  localparam int CALM_FIRST    = 700;
  localparam int CALM_LAST     = 1000;

  typedef logic signed [sli_pkg::VALUE_W-1:0] entry_t;

  typedef struct {
    logic   req;
    entry_t val;
    bit     drain;
  } request_t;

  typedef struct {
    sli_pkg::status_t                status;
    logic [sli_pkg::COUNT_OUT_W-1:0] count;
  } outcome_t;

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  logic                            req_type;
  entry_t                          value;
  logic                            done;
  logic [1:0]                      status;
  logic [sli_pkg::COUNT_OUT_W-1:0] entry_count;

  request_t pending_q[$];
  outcome_t outcome_q[$];
  entry_t   gen_vals[$];
  int       accepted_cnt;
  int       received_cnt;
  int       error_count;

  // Model of the list contents, advanced at each accepted transaction
  entry_t   list_vals[CAPACITY];
  int       list_count;

  sorted_list_insert_remove #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .value      (value),
    .done       (done),
    .status     (status),
    .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Apply one request to the list model and return its status and count
  task automatic apply_request(input logic req, input entry_t v, output outcome_t res);
    int pos;
    int i;
    res.status = sli_pkg::ST_OK;
    pos = 0;
    if (req == sli_pkg::REQ_INSERT) begin
      if (list_count >= CAPACITY) begin
        res.status = sli_pkg::ST_FULL;
      end else begin
        // insert in front of the first entry that is greater or equal
        while (pos < list_count && list_vals[pos] < v) pos++;
        for (i = list_count; i > pos; i--) list_vals[i] = list_vals[i-1];
        list_vals[pos] = v;
        list_count++;
      end
    end else begin
      if (list_count == 0) begin
        res.status = sli_pkg::ST_EMPTY;
      end else begin
        while (pos < list_count && list_vals[pos] != v) pos++;
        if (pos >= list_count) begin
          res.status = sli_pkg::ST_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < list_count; i++) list_vals[i] = list_vals[i+1];
          list_count--;
        end
      end
    end
    res.count = list_count[sli_pkg::COUNT_OUT_W-1:0];
  endtask

  // Queue a request and track list contents so removes can target held values
  task automatic queue_request(input logic req, input entry_t v, input bit drain);
    request_t r;
    int idx;
    r.req   = req;
    r.val   = v;
    r.drain = drain;
    pending_q.push_back(r);
    if (req == sli_pkg::REQ_INSERT) begin
      if (gen_vals.size() < CAPACITY) gen_vals.push_back(v);
    end else begin
      idx = -1;
      foreach (gen_vals[k]) if (idx < 0 && gen_vals[k] == v) idx = k;
      if (idx >= 0) gen_vals.delete(idx);
    end
  endtask

  // Mix of clustered small values (duplicates), extremes and full-range values
  function automatic entry_t pick_value();
    entry_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = entry_t'($urandom_range(0, 8)) - 4;
      4: begin
        case ($urandom_range(0, 5))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 32'sh8000_0001;
          3: v = 32'sh7fff_fffe;
          4: v = 0;
          default: v = -1;
        endcase
      end
      default: v = entry_t'($urandom);
    endcase
    return v;
  endfunction

  // Driver: present the head of the pending queue, hold it until accepted
  always @(posedge clk) begin : driver
    request_t head;
    outcome_t res;
    bit       took;
    bit       outstanding;
    bit       pause;
    took = 1'b0;
    if (!rst && start && !busy) begin
      head = pending_q.pop_front();
      apply_request(head.req, head.val, res);
      outcome_q.push_back(res);
      accepted_cnt <= accepted_cnt + 1;
      took = 1'b1;
    end
    if (!(start && !took) || rst) begin
      outstanding = took || (accepted_cnt != received_cnt);
      pause = ($urandom_range(0, 99) < 30) &&
              !(accepted_cnt >= CALM_FIRST && accepted_cnt < CALM_LAST);
      if (!rst && pending_q.size() != 0 && !pause &&
          !(pending_q[0].drain && outstanding)) begin
        start    <= 1'b1;
        req_type <= pending_q[0].req;
        value    <= pending_q[0].val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result against the oldest outstanding prediction
  always @(posedge clk) begin : monitor
    outcome_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d count=%0d",
                                  status, entry_count));
      end else begin
        want = outcome_q.pop_front();
        received_cnt <= received_cnt + 1;
        if (status !== want.status)
          report_mismatch($sformatf("transaction %0d: status %0d, want %0d",
                                    received_cnt, status, want.status));
        if (entry_count !== want.count)
          report_mismatch($sformatf("transaction %0d: entry_count %0d, want %0d",
                                    received_cnt, entry_count, want.count));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || done || (start && !busy)) quiet = 0;
      else quiet++;
    end
    $display("sorted_list_insert_remove: mismatch");
    $finish;
  end

  initial begin : stimulus
    int insert_pct;
    bit drain;
    start        = 1'b0;
    req_type     = sli_pkg::REQ_INSERT;
    value        = '0;
    accepted_cnt = 0;
    received_cnt = 0;
    error_count  = 0;
    list_count   = 0;
    insert_pct   = 50;

    // Directed: remove from empty, extremes, duplicates, miss, drain to empty
    queue_request(sli_pkg::REQ_REMOVE, 0, 1'b0);
    queue_request(sli_pkg::REQ_INSERT, 32'sh7fff_ffff, 1'b0);
    queue_request(sli_pkg::REQ_INSERT, 32'sh8000_0000, 1'b0);
    queue_request(sli_pkg::REQ_INSERT, 0, 1'b0);
    queue_request(sli_pkg::REQ_INSERT, -1, 1'b0);
    queue_request(sli_pkg::REQ_INSERT, 0, 1'b0);
    queue_request(sli_pkg::REQ_INSERT, 1, 1'b0);
    queue_request(sli_pkg::REQ_INSERT, 32'sh7fff_ffff, 1'b0);
    queue_request(sli_pkg::REQ_REMOVE, 5, 1'b0);
    queue_request(sli_pkg::REQ_REMOVE, 32'sh8000_0001, 1'b0);
    queue_request(sli_pkg::REQ_REMOVE, 0, 1'b0);
    queue_request(sli_pkg::REQ_REMOVE, 32'sh8000_0000, 1'b0);
    queue_request(sli_pkg::REQ_REMOVE, 32'sh7fff_ffff, 1'b0);
    queue_request(sli_pkg::REQ_REMOVE, 32'sh7fff_ffff, 1'b0);
    queue_request(sli_pkg::REQ_REMOVE, -1, 1'b0);
    queue_request(sli_pkg::REQ_REMOVE, 0, 1'b0);
    queue_request(sli_pkg::REQ_REMOVE, 1, 1'b0);
    queue_request(sli_pkg::REQ_REMOVE, -1, 1'b0);

    // Random: phases biased toward filling, churning or emptying the list
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      drain = (n % 250 == 0);
      if ($urandom_range(0, 99) < insert_pct)
        queue_request(sli_pkg::REQ_INSERT, pick_value(), drain);
      else if (gen_vals.size() != 0 && $urandom_range(0, 9) < 7)
        queue_request(sli_pkg::REQ_REMOVE,
                      gen_vals[$urandom_range(0, gen_vals.size() - 1)], drain);
      else
        queue_request(sli_pkg::REQ_REMOVE, pick_value(), drain);
    end

    // Wait for every transaction to be accepted and answered, then settle
    do @(posedge clk);
    while (rst || pending_q.size() != 0 || accepted_cnt != received_cnt);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (outcome_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));

    if (error_count == 0) begin
      $display("sorted_list_insert_remove: match");
    end else begin
      $display("sorted_list_insert_remove: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sli_pkg.sv
hw/rtl/sli_ram.sv
hw/rtl/sli_ctrl.sv
hw/rtl/sorted_list_insert_remove.sv
verif/testbench.sv
